FILE: rtl/core/dlqa_pkg.sv
`timescale 1ns / 1ps
// Package for the dual linear queue block: sizes, request and status codes,
// and the sequencer state type. Depends on nothing.
package dlqa_pkg;

   // Queue depth and the widths that follow from it.
   localparam int DEPTH    = 64;
   localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int DATA_W   = 32;
   localparam int MOVED_W  = 7;
   localparam int REQ_W    = 3;
   localparam int STATUS_W = 2;

   // Request codes.
   localparam logic [REQ_W-1:0] REQ_ENQ_X  = 3'd0;
   localparam logic [REQ_W-1:0] REQ_ENQ_Y  = 3'd1;
   localparam logic [REQ_W-1:0] REQ_READ_X = 3'd2;
   localparam logic [REQ_W-1:0] REQ_READ_Y = 3'd3;
   localparam logic [REQ_W-1:0] REQ_APPEND = 3'd4;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVF   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   // Sequencer states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_APPEND
   } state_type;

endpackage

FILE: rtl/core/dlqa_ram.sv
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with a registered read.
// Depends on nothing.
module dlqa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/dual_linear_queue_append.sv
`timescale 1ns / 1ps
// Top level of the dual linear queue block with append.
// Depends on dlqa_pkg and dlqa_ram.
//
// Two linear queues, X and Y, each hold up to DEPTH signed words in a RAM.
// A request is taken when start is high and busy is low. Enqueue requests
// are answered with one result on the cycle after the request; busy stays
// low, so a new request can follow at once. A read-out request walks the
// queue from head to fill, one RAM read per cycle, giving one result per
// element with rsp_last_result on the newest one; busy falls as the
// last result shows. An append walks X the same way, writing each word
// into Y in the cycle its read data returns, and gives one result with
// the count moved, and busy falls as that result shows. The single RAM
// read per cycle sets the rate. Reading or appending an empty queue
// gives one result with the empty status right after the request.
// Results are valid for one cycle while rsp_strobe is high; the receiver
// cannot stall them. Reset empties both queues; RAM contents are not
// cleared.
module dual_linear_queue_append (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [dlqa_pkg::REQ_W-1:0]            req_type,
   input  logic signed [dlqa_pkg::DATA_W-1:0]    req_item_value,
   output logic                                  rsp_strobe,
   output logic [dlqa_pkg::STATUS_W-1:0]         rsp_status,
   output logic signed [dlqa_pkg::DATA_W-1:0]    rsp_read_value,
   output logic [dlqa_pkg::MOVED_W-1:0]          rsp_moved_count,
   output logic                                  rsp_last_result
);
   import dlqa_pkg::*;

   state_type state_ff, state_in;

   logic [CNT_W-1:0] head_x_ff, head_x_in;
   logic [CNT_W-1:0] fill_x_ff, fill_x_in;
   logic [CNT_W-1:0] head_y_ff, head_y_in;
   logic [CNT_W-1:0] fill_y_ff, fill_y_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] moved_ff, moved_in;
   logic             lost_ff, lost_in;
   logic             src_y_ff, src_y_in;
   logic             pend_ff, pend_in;
   logic             pend_last_ff, pend_last_in;

   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]   rsp_value_ff, rsp_value_in;
   logic [MOVED_W-1:0]  rsp_moved_ff, rsp_moved_in;
   logic                rsp_last_ff, rsp_last_in;

   logic              wr_x_en, wr_y_en;
   logic [DATA_W-1:0] wr_x_data, wr_y_data;
   logic [DATA_W-1:0] rd_x_data, rd_y_data;
   logic              empty_x, empty_y;
   logic [CNT_W-1:0]  fill_sel;
   logic              accept;

   assign accept   = start && (state_ff == S_IDLE);
   assign empty_x  = (fill_x_ff == '0) || (head_x_ff >= fill_x_ff);
   assign empty_y  = (fill_y_ff == '0) || (head_y_ff >= fill_y_ff);
   assign fill_sel = (state_ff == S_READ && src_y_ff) ? fill_y_ff : fill_x_ff;

   // Queue storage.
   dlqa_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_x (
      .clock   (clock),
      .wr_en   (wr_x_en),
      .wr_addr (fill_x_ff[ADDR_W-1:0]),
      .wr_data (wr_x_data),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (rd_x_data)
   );

   dlqa_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_y (
      .clock   (clock),
      .wr_en   (wr_y_en),
      .wr_addr (fill_y_ff[ADDR_W-1:0]),
      .wr_data (wr_y_data),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (rd_y_data)
   );

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_type)
                  REQ_READ_X: if (!empty_x) state_in = S_READ;
                  REQ_READ_Y: if (!empty_y) state_in = S_READ;
                  REQ_APPEND: if (!empty_x) state_in = S_APPEND;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_READ, S_APPEND: begin
            if (pend_ff && pend_last_ff) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath: queue pointers, RAM accesses and results.
   always_comb begin
      logic [CNT_W-1:0] moved_now;
      logic             lost_now;

      moved_now     = moved_ff;
      lost_now      = lost_ff;
      head_x_in     = head_x_ff;
      fill_x_in     = fill_x_ff;
      head_y_in     = head_y_ff;
      fill_y_in     = fill_y_ff;
      idx_in        = idx_ff;
      moved_in      = moved_ff;
      lost_in       = lost_ff;
      src_y_in      = src_y_ff;
      pend_in       = 1'b0;
      pend_last_in  = 1'b0;
      wr_x_en       = 1'b0;
      wr_y_en       = 1'b0;
      wr_x_data     = $unsigned(req_item_value);
      wr_y_data     = $unsigned(req_item_value);
      rsp_strobe_in = 1'b0;
      rsp_status_in = ST_OK;
      rsp_value_in  = '0;
      rsp_moved_in  = '0;
      rsp_last_in   = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_type)
                  REQ_ENQ_X: begin
                     rsp_strobe_in = 1'b1;
                     rsp_last_in   = 1'b1;
                     if (fill_x_ff < CNT_W'(DEPTH)) begin
                        wr_x_en   = 1'b1;
                        fill_x_in = fill_x_ff + 1'b1;
                        if (fill_x_ff == '0) head_x_in = '0;
                     end else begin
                        rsp_status_in = ST_OVF;
                     end
                  end
                  REQ_ENQ_Y: begin
                     rsp_strobe_in = 1'b1;
                     rsp_last_in   = 1'b1;
                     if (fill_y_ff < CNT_W'(DEPTH)) begin
                        wr_y_en   = 1'b1;
                        fill_y_in = fill_y_ff + 1'b1;
                        if (fill_y_ff == '0) head_y_in = '0;
                     end else begin
                        rsp_status_in = ST_OVF;
                     end
                  end
                  REQ_READ_X: begin
                     if (empty_x) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_EMPTY;
                        rsp_last_in   = 1'b1;
                     end else begin
                        idx_in   = head_x_ff;
                        src_y_in = 1'b0;
                     end
                  end
                  REQ_READ_Y: begin
                     if (empty_y) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_EMPTY;
                        rsp_last_in   = 1'b1;
                     end else begin
                        idx_in   = head_y_ff;
                        src_y_in = 1'b1;
                     end
                  end
                  REQ_APPEND: begin
                     if (empty_x) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_EMPTY;
                        rsp_last_in   = 1'b1;
                     end else begin
                        idx_in   = head_x_ff;
                        moved_in = '0;
                        lost_in  = 1'b0;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b0;
                  end
               endcase
            end
         end

         S_READ: begin
            // Issue the next read while elements remain.
            if (idx_ff != fill_sel) begin
               pend_in      = 1'b1;
               pend_last_in = ((idx_ff + 1'b1) == fill_sel);
               idx_in       = idx_ff + 1'b1;
            end
            // The read issued last cycle returns now.
            if (pend_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_value_in  = src_y_ff ? rd_y_data : rd_x_data;
               rsp_last_in   = pend_last_ff;
            end
         end

         S_APPEND: begin
            if (idx_ff != fill_x_ff) begin
               pend_in      = 1'b1;
               pend_last_in = ((idx_ff + 1'b1) == fill_x_ff);
               idx_in       = idx_ff + 1'b1;
            end
            // Move the returned word into Y if there is room.
            if (pend_ff) begin
               wr_y_data = rd_x_data;
               if (fill_y_ff < CNT_W'(DEPTH)) begin
                  wr_y_en   = 1'b1;
                  fill_y_in = fill_y_ff + 1'b1;
                  if (fill_y_ff == '0) head_y_in = '0;
                  moved_now = moved_ff + 1'b1;
               end else begin
                  lost_now = 1'b1;
               end
               moved_in = moved_now;
               lost_in  = lost_now;
               if (pend_last_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = lost_now ? ST_OVF : ST_OK;
                  rsp_moved_in  = MOVED_W'(moved_now);
                  rsp_last_in   = 1'b1;
                  head_x_in     = '0;
                  fill_x_in     = '0;
               end
            end
         end

         default: begin
            rsp_strobe_in = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_x_ff     <= '0;
         fill_x_ff     <= '0;
         head_y_ff     <= '0;
         fill_y_ff     <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_x_ff     <= head_x_in;
         fill_x_ff     <= fill_x_in;
         head_y_ff     <= head_y_in;
         fill_y_ff     <= fill_y_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Walk and result payload registers.
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      moved_ff      <= moved_in;
      lost_ff       <= lost_in;
      src_y_ff      <= src_y_in;
      pend_last_ff  <= pend_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_moved_ff  <= rsp_moved_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = $signed(rsp_value_ff);
   assign rsp_moved_count = rsp_moved_ff;
   assign rsp_last_result = rsp_last_ff;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for dual_linear_queue_append: a queue-fed request driver,
// a response monitor with a built-in predictor of both queues. Depends on dlqa_pkg.
module tb_top;
   import dlqa_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int RANDOM_REQUESTS = 380;

   // One pending request for the driver.
   typedef struct {
      logic [REQ_W-1:0]         kind;
      logic signed [DATA_W-1:0] word;
      int                       idle_pct;
      bit                       drain_first;
   } request_type;

   // One response as the block should give it.
   typedef struct {
      logic [STATUS_W-1:0]      status;
      logic signed [DATA_W-1:0] value;
      logic [MOVED_W-1:0]       moved;
      logic                     last;
   } answer_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic [REQ_W-1:0]         req_type = REQ_ENQ_X;
   logic signed [DATA_W-1:0] req_item_value = '0;
   logic                     busy;
   logic                     rsp_strobe;
   logic [STATUS_W-1:0]      rsp_status;
   logic signed [DATA_W-1:0] rsp_read_value;
   logic [MOVED_W-1:0]       rsp_moved_count;
   logic                     rsp_last_result;

   request_type pending_requests[$];
   answer_type  due_answers[$];
   int          mismatches = 0;
   int          quiet_cycles = 0;

   // Predicted contents of both queues.
   logic signed [DATA_W-1:0] x_words[DEPTH];
   logic signed [DATA_W-1:0] y_words[DEPTH];
   int x_head = 0, x_fill = 0, y_head = 0, y_fill = 0;

   dual_linear_queue_append DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_item_value  (req_item_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value),
      .rsp_moved_count (rsp_moved_count),
      .rsp_last_result (rsp_last_result)
   );

   always #5 clock = ~clock;

   function automatic void note_answer(logic [STATUS_W-1:0] st, logic signed [DATA_W-1:0] v,
                                       logic [MOVED_W-1:0] m, logic l);
      answer_type a;
      a.status = st;
      a.value  = v;
      a.moved  = m;
      a.last   = l;
      due_answers.push_back(a);
   endfunction

   // Stores a word at the write index; a full queue drops it.
   function automatic bit store_word(bit to_y, logic signed [DATA_W-1:0] w);
      if (to_y) begin
         if (y_fill >= DEPTH) return 1'b0;
         if (y_fill == 0) y_head = 0;
         y_words[y_fill] = w;
         y_fill++;
      end else begin
         if (x_fill >= DEPTH) return 1'b0;
         if (x_fill == 0) x_head = 0;
         x_words[x_fill] = w;
         x_fill++;
      end
      return 1'b1;
   endfunction

   // A read-out lists every element from head to fill, or reports empty.
   function automatic void predict_read_out(bit from_y);
      int h, f;
      h = from_y ? y_head : x_head;
      f = from_y ? y_fill : x_fill;
      if (f == 0 || h >= f) begin
         note_answer(ST_EMPTY, '0, '0, 1'b1);
      end else begin
         for (int i = h; i < f; i++)
            note_answer(ST_OK, from_y ? y_words[i] : x_words[i], '0, (i + 1 == f));
      end
   endfunction

   // Works out the responses of one accepted request and updates the queues.
   function automatic void predict_request(logic [REQ_W-1:0] kind,
                                           logic signed [DATA_W-1:0] word);
      int  moved;
      bit  lost;
      case (kind)
         REQ_ENQ_X: begin
            note_answer(store_word(1'b0, word) ? ST_OK : ST_OVF, '0, '0, 1'b1);
         end
         REQ_ENQ_Y: begin
            note_answer(store_word(1'b1, word) ? ST_OK : ST_OVF, '0, '0, 1'b1);
         end
         REQ_READ_X: predict_read_out(1'b0);
         REQ_READ_Y: predict_read_out(1'b1);
         REQ_APPEND: begin
            if (x_fill == 0 || x_head >= x_fill) begin
               note_answer(ST_EMPTY, '0, '0, 1'b1);
            end else begin
               moved = 0;
               lost  = 1'b0;
               for (int i = x_head; i < x_fill; i++) begin
                  if (store_word(1'b1, x_words[i])) moved++;
                  else lost = 1'b1;
               end
               x_head = 0;
               x_fill = 0;
               note_answer(lost ? ST_OVF : ST_OK, '0, moved[MOVED_W-1:0], 1'b1);
            end
         end
         default: ;  // unknown codes are ignored by the block
      endcase
   endfunction

   // Driver: presents the next pending request, with random idle cycles and an
   // optional wait until the block has answered everything.
   always @(posedge clock) begin
      bit give;
      give = 1'b0;
      if (!reset && (!start || !busy)) begin
         if (pending_requests.size() != 0) begin
            if (pending_requests[0].drain_first &&
                (start || busy || due_answers.size() != 0))
               give = 1'b0;
            else if ($urandom_range(99) < pending_requests[0].idle_pct)
               give = 1'b0;
            else
               give = 1'b1;
         end
         start <= give;
         if (give) begin
            req_type       <= pending_requests[0].kind;
            req_item_value <= pending_requests[0].word;
            pending_requests.pop_front();
         end
      end
   end

   // Monitor: checks each response against the oldest prediction, then
   // predicts the request accepted at this edge.
   always @(posedge clock) begin
      answer_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (due_answers.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected response status=%0d value=%0d moved=%0d last=%0b",
                           $realtime, rsp_status, rsp_read_value, rsp_moved_count,
                           rsp_last_result);
            end else begin
               want = due_answers.pop_front();
               if (rsp_status !== want.status || rsp_read_value !== want.value ||
                   rsp_moved_count !== want.moved || rsp_last_result !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"%0t: mismatch expected status=%0d value=%0d moved=%0d ",
                               "last=%0b, got status=%0d value=%0d moved=%0d last=%0b"},
                              $realtime, want.status, want.value, want.moved, want.last,
                              rsp_status, rsp_read_value, rsp_moved_count, rsp_last_result);
               end
            end
         end
         if (start && !busy)
            predict_request(req_type, req_item_value);
      end
   end

   // Watchdog: ends the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic void add_request(logic [REQ_W-1:0] kind, logic signed [DATA_W-1:0] word,
                                       int idle_pct, bit drain_first);
      request_type r;
      r.kind        = kind;
      r.word        = word;
      r.idle_pct    = idle_pct;
      r.drain_first = drain_first;
      pending_requests.push_back(r);
   endfunction

   // Random word, with the extremes mixed in now and then.
   function automatic logic signed [DATA_W-1:0] pick_word();
      case ($urandom_range(9))
         0:       return 32'h7fff_ffff;
         1:       return 32'h8000_0000;
         2:       return 32'hffff_ffff;
         3:       return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   // Stimulus and end of run.
   initial begin
      int counted, phase, last_phase, idle_pct, roll, bursts, span;
      int idle_by_phase[4];
      bit drain;
      idle_by_phase = '{0, 61, 0, 6};

      // Directed: empty queues, extreme words, every request and the unknown codes.
      add_request(REQ_READ_X, '0, 0, 1'b0);
      add_request(REQ_READ_Y, '0, 0, 1'b0);
      add_request(REQ_APPEND, '0, 0, 1'b0);
      add_request(REQ_ENQ_X, 32'h7fff_ffff, 0, 1'b0);
      add_request(REQ_ENQ_X, 32'h8000_0000, 0, 1'b0);
      add_request(REQ_ENQ_X, 32'hffff_ffff, 0, 1'b0);
      add_request(REQ_ENQ_X, 32'h0000_0000, 0, 1'b0);
      add_request(REQ_ENQ_Y, 32'h0000_0001, 0, 1'b0);
      add_request(REQ_ENQ_Y, 32'h8000_0000, 0, 1'b0);
      add_request(REQ_READ_X, '0, 0, 1'b0);
      add_request(REQ_READ_Y, '0, 0, 1'b0);
      add_request(REQ_APPEND, 32'h1234_5678, 0, 1'b0);
      add_request(REQ_READ_X, '0, 0, 1'b0);
      add_request(REQ_READ_Y, '0, 0, 1'b0);
      add_request(3'd5, 32'hdead_beef, 0, 1'b0);
      add_request(3'd6, 32'h0, 0, 1'b0);
      add_request(3'd7, 32'hffff_ffff, 0, 1'b0);
      add_request(REQ_ENQ_X, 32'h5555_5555, 0, 1'b0);
      add_request(REQ_ENQ_X, 32'haaaa_aaaa, 0, 1'b0);
      add_request(REQ_APPEND, '0, 0, 1'b0);
      add_request(REQ_READ_Y, '0, 0, 1'b0);

      // Random: a weighted mix, and later bursts that overfill X and then Y.
      counted    = 0;
      last_phase = -1;
      bursts     = 0;
      while (counted < RANDOM_REQUESTS) begin
         phase    = counted * 4 / RANDOM_REQUESTS;
         idle_pct = idle_by_phase[phase];
         drain    = (phase != last_phase);
         last_phase = phase;
         roll = $urandom_range(99);
         if (counted > 200 && bursts < 3 && roll < 8) begin
            bursts++;
            span = $urandom_range(60, 70);
            for (int i = 0; i < span; i++)
               add_request(REQ_ENQ_X, pick_word(), idle_pct, drain && i == 0);
            add_request(REQ_READ_X, '0, idle_pct, 1'b0);
            add_request(REQ_APPEND, pick_word(), idle_pct, 1'b0);
            counted += span + 2;
         end else if (roll < 35) begin
            add_request(REQ_ENQ_X, pick_word(), idle_pct, drain);
            counted++;
         end else if (roll < 50) begin
            add_request(REQ_ENQ_Y, pick_word(), idle_pct, drain);
            counted++;
         end else if (roll < 62) begin
            add_request(REQ_READ_X, pick_word(), idle_pct, drain);
            counted++;
         end else if (roll < 72) begin
            add_request(REQ_READ_Y, pick_word(), idle_pct, drain);
            counted++;
         end else if (roll < 95) begin
            add_request(REQ_APPEND, pick_word(), idle_pct, drain);
            counted++;
         end else begin
            // Ignored codes do not count as requests.
            add_request(3'($urandom_range(7, 5)), pick_word(), idle_pct, drain);
            last_phase = -1;
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Let every request go out, every response come back, then a tail.
      do @(posedge clock); while (pending_requests.size() != 0 || start);
      do @(posedge clock); while (due_answers.size() != 0);
      repeat (DEPTH + 40) @(posedge clock);

      if (mismatches == 0 && due_answers.size() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/dlqa_pkg.sv
rtl/core/dlqa_ram.sv
rtl/core/dual_linear_queue_append.sv
bench/tb_top.sv
